FILE: rtl/core/frame_bitmap_allocator_unit_assert.svh
// Assertion macros for the frame bitmap allocator.
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fba_pkg.sv
// Shared constants and codes of the frame bitmap allocator.
package fba_pkg;

  localparam int FRAME_COUNT = 4096;
  localparam int FRAME_W     = 12;
  localparam int CFG_W       = 13;
  localparam int WORD_W      = 64;
  localparam int BIT_AW      = $clog2(WORD_W);
  localparam int ROWS        = FRAME_COUNT / WORD_W;
  localparam int ROW_AW      = $clog2(ROWS);
  localparam int LIM_ROW_W   = CFG_W - BIT_AW;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_NOTHING  = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  typedef struct packed {
    logic               present;
    logic               rw;
    logic               user;
    logic [FRAME_W-1:0] frame;
    logic [1:0]         status;
  } result_t;

endpackage

FILE: rtl/core/frame_bitmap_allocator_unit.sv
// Frame bitmap allocator: first-fit allocate and free of physical frames.
// After the input transfer, row select with memory read is followed by bit search with
// read-modify-write, and the result is registered onto out_tdata with out_tvalid.
// One item is in flight at a time, as in_tready is high only while the unit is idle;
// a result that is not taken holds the next item's write-back until it is.
// Synchronous active-low reset clears control, the row-full and row-valid flags, which
// makes the whole bitmap read as free, and sets the frame limit to 4096.
`include "frame_bitmap_allocator_unit_assert.svh"

module frame_bitmap_allocator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // entry_present, entry_rw, entry_user, entry_frame[11:0], for_kernel, make_writable
  input  logic [fba_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // new_present, new_rw, new_user, new_frame[11:0], status[1:0]
  output logic [fba_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [fba_pkg::CFG_W-1:0]       cfg_wr_data
);
  import fba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEL  = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic               act_r, present_r, rw_r, user_r, kernel_r, wrt_r;
  logic [FRAME_W-1:0] frame_r;
  logic [CFG_W-1:0]   frames_r;
  logic [ROWS-1:0]    full_r, row_valid_r;
  logic [WORD_W-1:0]  bitmap_mem [ROWS];
  logic [WORD_W-1:0]  rd_data_r;
  logic               rd_valid_r;
  logic [ROW_AW-1:0]  row_r;
  logic               row_found_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_data_r, res;

  logic                 in_fire, commit, mem_we;
  logic [CFG_W-1:0]     lim;
  logic [LIM_ROW_W-1:0] lim_rows;
  logic [ROWS-1:0]      row_elig;
  logic [ROW_AW-1:0]    row_sel, alloc_row;
  logic                 alloc_row_found;
  logic [WORD_W-1:0]    word, free_bits, new_word;
  logic [BIT_AW-1:0]    bit_idx;
  logic                 bit_found, alloc_need, alloc_ok, free_do;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign commit    = (state_r == S_MOD) && (!out_valid_r || out_tready);

  always_comb begin
    if (frames_r > CFG_W'(FRAME_COUNT)) begin
      lim = CFG_W'(FRAME_COUNT);
    end else begin
      lim = {frames_r[CFG_W-1:3], 3'b000};
    end
    lim_rows = lim[CFG_W-1:BIT_AW] + LIM_ROW_W'(|lim[BIT_AW-1:0]);
  end

  always_comb begin
    alloc_row       = '0;
    alloc_row_found = 1'b0;
    for (int w = ROWS - 1; w >= 0; w--) begin
      row_elig[w] = !full_r[w] && (LIM_ROW_W'(w) < lim_rows);
      if (row_elig[w]) begin
        alloc_row       = ROW_AW'(w);
        alloc_row_found = 1'b1;
      end
    end
    row_sel = (act_r == ACTION_ALLOC) ? alloc_row : frame_r[FRAME_W-1:BIT_AW];
  end

  always_comb begin
    word      = rd_valid_r ? rd_data_r : '0;
    bit_idx   = '0;
    bit_found = 1'b0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      free_bits[b] = !word[b] && ({1'b0, row_r, BIT_AW'(b)} < lim);
      if (free_bits[b]) begin
        bit_idx   = BIT_AW'(b);
        bit_found = 1'b1;
      end
    end
    alloc_need = (act_r == ACTION_ALLOC) && !present_r;
    alloc_ok   = alloc_need && row_found_r && bit_found;
    free_do    = (act_r == ACTION_FREE) && present_r;
    if (alloc_ok) begin
      new_word = word | (WORD_W'(1) << bit_idx);
    end else begin
      new_word = word & ~(WORD_W'(1) << frame_r[BIT_AW-1:0]);
    end
    mem_we = commit && (alloc_ok || free_do);

    res.present = present_r;
    res.rw      = rw_r;
    res.user    = user_r;
    res.frame   = frame_r;
    res.status  = STATUS_NOTHING;
    if (alloc_ok) begin
      res.present = 1'b1;
      res.rw      = wrt_r;
      res.user    = !kernel_r;
      res.frame   = {row_r, bit_idx};
      res.status  = STATUS_DONE;
    end else if (alloc_need) begin
      res.status  = STATUS_NO_FRAME;
    end else if (free_do) begin
      res.present = 1'b0;
      res.frame   = '0;
      res.status  = STATUS_DONE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_SEL;
      S_SEL:   state_nxt = S_MOD;
      S_MOD:   if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = commit || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      frames_r    <= CFG_W'(FRAME_COUNT);
      full_r      <= '0;
      row_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        frames_r <= cfg_wr_data;
      end
      if (mem_we) begin
        full_r[row_r]      <= &new_word;
        row_valid_r[row_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r     <= in_tuser;
      present_r <= in_tdata[0];
      rw_r      <= in_tdata[1];
      user_r    <= in_tdata[2];
      frame_r   <= in_tdata[14:3];
      kernel_r  <= in_tdata[15];
      wrt_r     <= in_tdata[16];
    end
    if (state_r == S_SEL) begin
      row_r       <= row_sel;
      row_found_r <= (act_r == ACTION_FREE) || alloc_row_found;
      rd_valid_r  <= row_valid_r[row_sel];
    end
    if (commit) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[row_r] <= new_word;
    end
    if (state_r == S_SEL) begin
      rd_data_r <= bitmap_mem[row_sel];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_data_r.status, out_data_r.frame,
                       out_data_r.user, out_data_r.rw, out_data_r.present};

  `FBA_ASSERT_NEXT(a_accept_to_sel, in_fire, state_r == S_SEL, "no row select after transfer")
  `FBA_ASSERT_SAME(a_alloc_lim, commit && alloc_ok, {1'b0, res.frame} < lim, "beyond limit")
  `FBA_ASSERT_SAME(a_full_is_valid, 1'b1, (full_r & ~row_valid_r) == '0, "full row never written")

endmodule

FILE: tb/sv/tb_frame_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frame bitmap allocator unit with a first-fit bitmap predictor.
module tb_frame_bitmap_allocator_unit;
  import fba_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic               action;
    logic               present;
    logic               rw;
    logic               user;
    logic [FRAME_W-1:0] frame;
    logic               for_kernel;
    logic               make_writable;
  } page_request_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tuser    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  bit                 frame_used [0:FRAME_COUNT-1];
  int unsigned        frame_limit = 4096;
  logic [FRAME_W-1:0] held_frames[$];
  result_t            expected_entries[$];
  int                 mismatches   = 0;
  int                 stuck_cycles = 0;
  int                 stall_left   = 0;
  bit                 idle_on      = 1'b1;

  frame_bitmap_allocator_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic result_t predict_page_update(input page_request_t req);
    result_t     res;
    int unsigned scan_limit;
    int          found;
    res.present = req.present;
    res.rw      = req.rw;
    res.user    = req.user;
    res.frame   = req.frame;
    res.status  = STATUS_NOTHING;
    if (req.action == ACTION_ALLOC) begin
      if (!req.present) begin
        scan_limit = (frame_limit > FRAME_COUNT) ? FRAME_COUNT : frame_limit;
        scan_limit = (scan_limit >> 3) << 3;
        found = -1;
        for (int i = 0; i < scan_limit && found < 0; i++) begin
          if (!frame_used[i]) found = i;
        end
        if (found >= 0) begin
          frame_used[found] = 1'b1;
          held_frames.push_back(found[FRAME_W-1:0]);
          res.present = 1'b1;
          res.rw      = req.make_writable;
          res.user    = ~req.for_kernel;
          res.frame   = found[FRAME_W-1:0];
          res.status  = STATUS_DONE;
        end else begin
          res.status = STATUS_NO_FRAME;
        end
      end
    end else if (req.present) begin
      if (req.frame < FRAME_COUNT) frame_used[req.frame] = 1'b0;
      for (int k = held_frames.size() - 1; k >= 0; k--) begin
        if (held_frames[k] == req.frame) held_frames.delete(k);
      end
      res.present = 1'b0;
      res.frame   = '0;
      res.status  = STATUS_DONE;
    end
    return res;
  endfunction

  task automatic submit_page_request(input logic action, input logic present, input logic rw,
                                     input logic user, input logic [FRAME_W-1:0] frame,
                                     input logic for_kernel, input logic make_writable);
    page_request_t req;
    req.action        = action;
    req.present       = present;
    req.rw            = rw;
    req.user          = user;
    req.frame         = frame;
    req.for_kernel    = for_kernel;
    req.make_writable = make_writable;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {7'd0, make_writable, for_kernel, frame, user, rw, present};
    do @(posedge clk); while (!in_tready);
    expected_entries.push_back(predict_page_update(req));
  endtask

  task automatic finish_outstanding();
    in_tvalid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frames_in_use(input logic [CFG_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    frame_limit = 32'(value);
    @(posedge clk);
  endtask

  task automatic test_first_fit_alloc();
    submit_page_request(ACTION_ALLOC, 1'b0, 1'b1, 1'b1, 12'hFFF, 1'b0, 1'b0);
    submit_page_request(ACTION_ALLOC, 1'b0, 1'b0, 1'b0, 12'h000, 1'b1, 1'b1);
    submit_page_request(ACTION_ALLOC, 1'b0, 1'b1, 1'b0, 12'hAAA, 1'b0, 1'b1);
    submit_page_request(ACTION_ALLOC, 1'b0, 1'b0, 1'b1, 12'h555, 1'b1, 1'b0);
    submit_page_request(ACTION_ALLOC, 1'b1, 1'b1, 1'b1, 12'hFFF, 1'b1, 1'b1);
    submit_page_request(ACTION_ALLOC, 1'b1, 1'b0, 1'b0, 12'h000, 1'b0, 1'b0);
  endtask

  task automatic test_free_paths();
    submit_page_request(ACTION_FREE, 1'b1, 1'b1, 1'b1, 12'd1, 1'b0, 1'b0);
    submit_page_request(ACTION_FREE, 1'b0, 1'b1, 1'b1, 12'hFFF, 1'b1, 1'b1);
    submit_page_request(ACTION_FREE, 1'b1, 1'b0, 1'b0, 12'hFFF, 1'b1, 1'b1);
    submit_page_request(ACTION_ALLOC, 1'b0, 1'b0, 1'b0, 12'h000, 1'b0, 1'b0);
  endtask

  task automatic test_small_limits();
    finish_outstanding();
    set_frames_in_use(13'd8);
    repeat (5) submit_page_request(ACTION_ALLOC, 1'b0, 1'b0, 1'b0, 12'h000, 1'b0, 1'b1);
    finish_outstanding();
    set_frames_in_use(13'd7);
    submit_page_request(ACTION_ALLOC, 1'b0, 1'b1, 1'b1, 12'h123, 1'b1, 1'b1);
    finish_outstanding();
    set_frames_in_use(13'd0);
    submit_page_request(ACTION_ALLOC, 1'b0, 1'b1, 1'b1, 12'h321, 1'b0, 1'b0);
  endtask

  task automatic test_lowered_limit();
    finish_outstanding();
    set_frames_in_use(13'd16);
    repeat (2) submit_page_request(ACTION_ALLOC, 1'b0, 1'b0, 1'b0, 12'h000, 1'b0, 1'b0);
    finish_outstanding();
    set_frames_in_use(13'd8);
    submit_page_request(ACTION_ALLOC, 1'b0, 1'b0, 1'b0, 12'h000, 1'b0, 1'b0);
    submit_page_request(ACTION_FREE, 1'b1, 1'b1, 1'b0, 12'd9, 1'b0, 1'b0);
    finish_outstanding();
    set_frames_in_use(13'd16);
    submit_page_request(ACTION_ALLOC, 1'b0, 1'b0, 1'b0, 12'h000, 1'b1, 1'b1);
  endtask

  task automatic test_wide_limit();
    finish_outstanding();
    set_frames_in_use(13'h1FFF);
    submit_page_request(ACTION_ALLOC, 1'b0, 1'b1, 1'b0, 12'h800, 1'b1, 1'b0);
  endtask

  task automatic test_random_mix(input logic [CFG_W-1:0] limit, input int count,
                                 input bit with_idle);
    int                 pick;
    logic [FRAME_W-1:0] frame;
    logic [3:0]         noise;
    finish_outstanding();
    set_frames_in_use(limit);
    idle_on = with_idle;
    repeat (count) begin
      pick  = int'($urandom_range(0, 99));
      frame = FRAME_W'($urandom());
      noise = 4'($urandom());
      if (pick < 50) begin
        submit_page_request(ACTION_ALLOC, 1'b0, noise[0], noise[1], frame, noise[2], noise[3]);
      end else if (pick < 75 && held_frames.size() != 0) begin
        submit_page_request(ACTION_FREE, 1'b1, noise[0], noise[1],
                            held_frames[$urandom_range(0, held_frames.size() - 1)],
                            noise[2], noise[3]);
      end else if (pick < 83) begin
        submit_page_request(ACTION_ALLOC, 1'b1, noise[0], noise[1], frame, noise[2], noise[3]);
      end else if (pick < 93) begin
        submit_page_request(ACTION_FREE, 1'b1, noise[0], noise[1], frame, noise[2], noise[3]);
      end else begin
        submit_page_request(ACTION_FREE, 1'b0, noise[0], noise[1], frame, noise[2], noise[3]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = int'($urandom_range(0, 13));
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.present = out_tdata[0];
      seen.rw      = out_tdata[1];
      seen.user    = out_tdata[2];
      seen.frame   = out_tdata[14:3];
      seen.status  = out_tdata[16:15];
      if (expected_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected result transfer: tdata %h", out_tdata);
        end
      end else begin
        want = expected_entries.pop_front();
        if (seen.present !== want.present || seen.rw !== want.rw || seen.user !== want.user ||
            seen.frame !== want.frame || seen.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Entry mismatch: expected p=%0b rw=%0b u=%0b frame=%0d status=%0d",
                     want.present, want.rw, want.user, want.frame, want.status);
            $display("                got      p=%0b rw=%0b u=%0b frame=%0d status=%0d",
                     seen.present, seen.rw, seen.user, seen.frame, seen.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_fit_alloc();
    test_free_paths();
    test_small_limits();
    test_lowered_limit();
    test_wide_limit();
    test_random_mix(13'd8, 120, 1'b1);
    test_random_mix(13'd16, 120, 1'b1);
    test_random_mix(13'd64, 130, 1'b1);
    test_random_mix(13'h1FFF, 130, 1'b1);
    test_random_mix(13'd24, 120, 1'b1);
    test_random_mix(13'd4095, 130, 1'b1);
    test_random_mix(13'd200, 130, 1'b1);
    test_random_mix(13'd9, 120, 1'b1);
    test_random_mix(13'd4096, 200, 1'b0);
    finish_outstanding();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/fba_pkg.sv
rtl/core/frame_bitmap_allocator_unit.sv
tb/sv/tb_frame_bitmap_allocator_unit.sv
